FILE: rtl/core/s2l_pkg.sv
`default_nettype none

package s2l_pkg;

  // number of lunar years covered by the year code table
  localparam int unsigned TABLE_YEARS = 101;
  localparam int unsigned YIDX_W      = $clog2(TABLE_YEARS);
  localparam int unsigned ACC_W       = 16;
  localparam int unsigned DAYCNT_W    = 18;
  localparam int unsigned MONTHS      = 12;

  localparam logic [11:0] BASE_YEAR   = 12'd2000;
  localparam logic [4:0]  SHORT_MONTH = 5'd29;
  localparam logic [4:0]  LEAP_BASE   = 5'd16;

  // output of the shared add and compare unit
  typedef struct packed {
    logic [ACC_W-1:0] sum;
    logic             hit;
  } s2l_step_t;

  // per-year code: bits 11..0 month lengths, bits 15..12 next year's leap position
  function automatic logic [15:0] year_code(input logic [YIDX_W-1:0] idx);
    logic [15:0] c;
    case (idx)
      7'd0:   c = 16'h4693;
      7'd1:   c = 16'hDA9B;  7'd2:   c = 16'h052B;  7'd3:   c = 16'h2A5B;
      7'd4:   c = 16'hDAAE;  7'd5:   c = 16'h756A;  7'd6:   c = 16'hDDD5;
      7'd7:   c = 16'h0BA4;  7'd8:   c = 16'h5B49;  7'd9:   c = 16'hDD53;
      7'd10:  c = 16'h0A95;  7'd11:  c = 16'h452D;  7'd12:  c = 16'hD55D;
      7'd13:  c = 16'h9AB5;  7'd14:  c = 16'hDBAA;  7'd15:  c = 16'h05D2;
      7'd16:  c = 16'h6DA5;  7'd17:  c = 16'hEE8A;  7'd18:  c = 16'h0D4A;
      7'd19:  c = 16'h4C95;  7'd20:  c = 16'hDA9E;  7'd21:  c = 16'h0556;
      7'd22:  c = 16'h2AB5;  7'd23:  c = 16'hDADA;  7'd24:  c = 16'h66D2;
      7'd25:  c = 16'hD765;  7'd26:  c = 16'h0725;  7'd27:  c = 16'h564B;
      7'd28:  c = 16'hD657;  7'd29:  c = 16'h0CAB;  7'd30:  c = 16'h355A;
      7'd31:  c = 16'hD56E;  7'd32:  c = 16'hBB69;  7'd33:  c = 16'hDF52;
      7'd34:  c = 16'h0B52;  7'd35:  c = 16'h5B25;  7'd36:  c = 16'hDD2B;
      7'd37:  c = 16'h0A4B;  7'd38:  c = 16'h54AB;  7'd39:  c = 16'hD2BB;
      7'd40:  c = 16'h05AD;  7'd41:  c = 16'h2B6A;  7'd42:  c = 16'hDDAA;
      7'd43:  c = 16'h7D92;  7'd44:  c = 16'hDEA5;  7'd45:  c = 16'h0D25;
      7'd46:  c = 16'h5A55;  7'd47:  c = 16'hEA4D;  7'd48:  c = 16'h04B6;
      7'd49:  c = 16'h35B5;  7'd50:  c = 16'hE6D2;  7'd51:  c = 16'h8EC9;
      7'd52:  c = 16'hDF92;  7'd53:  c = 16'h0E92;  7'd54:  c = 16'h6D26;
      7'd55:  c = 16'hE516;  7'd56:  c = 16'h0A57;  7'd57:  c = 16'h44D6;
      7'd58:  c = 16'hE365;  7'd59:  c = 16'h0755;  7'd60:  c = 16'h3749;
      7'd61:  c = 16'hD74B;  7'd62:  c = 16'h7693;  7'd63:  c = 16'hDAAB;
      7'd64:  c = 16'h052B;  7'd65:  c = 16'h5A5B;  7'd66:  c = 16'hDABA;
      7'd67:  c = 16'h056A;  7'd68:  c = 16'h4B65;  7'd69:  c = 16'hDBAA;
      7'd70:  c = 16'h8B4A;  7'd71:  c = 16'hDD95;  7'd72:  c = 16'h0A95;
      7'd73:  c = 16'h652D;  7'd74:  c = 16'hD56D;  7'd75:  c = 16'h0AB5;
      7'd76:  c = 16'h55AA;  7'd77:  c = 16'hE5C5;  7'd78:  c = 16'h0DA5;
      7'd79:  c = 16'h3D4A;  7'd80:  c = 16'hDE4D;  7'd81:  c = 16'h7C96;
      7'd82:  c = 16'hDCCE;  7'd83:  c = 16'h0556;  7'd84:  c = 16'h5AB5;
      7'd85:  c = 16'hEAD2;  7'd86:  c = 16'h06D2;  7'd87:  c = 16'h5EA5;
      7'd88:  c = 16'hD72A;  7'd89:  c = 16'h868B;  7'd90:  c = 16'hD697;
      7'd91:  c = 16'h04AB;  7'd92:  c = 16'h655B;  7'd93:  c = 16'hE556;
      7'd94:  c = 16'h0B6A;  7'd95:  c = 16'h4752;  7'd96:  c = 16'hDB95;
      7'd97:  c = 16'h0B25;  7'd98:  c = 16'h2A8B;  7'd99:  c = 16'hDA4F;
      7'd100: c = 16'h04AB;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/s2l_day_count.sv
`default_nettype none

// gregorian date to a signed day count, rebased to lunar new year 2000
module s2l_day_count
  import s2l_pkg::*;
(
  input  logic [6:0]                 year_i,
  input  logic [3:0]                 month_i,
  input  logic [4:0]                 day_i,
  output logic signed [DAYCNT_W-1:0] count_o
);

  logic [15:0]                 y365;
  logic [7:0]                  y_plus;
  logic [5:0]                  quad;
  logic signed [DAYCNT_W-1:0]  m_s;
  logic signed [DAYCNT_W-1:0]  m_term;
  logic signed [3:0]           fix;
  logic                        leap_inc;

  always_comb begin
    y365     = {9'b0, year_i} * 16'd365;
    y_plus   = {1'b0, year_i} + 8'd3;
    quad     = y_plus[7:2];
    m_s      = $signed({14'b0, month_i}) - 18'sd1;
    m_term   = (m_s <<< 5) - (m_s <<< 1);
    leap_inc = (month_i > 4'd2) && (year_i[1:0] == 2'b00) && (year_i != 7'd100);
    case (month_i)
      4'd3:                 fix = -4'sd1;
      4'd11, 4'd12:         fix = 4'sd4;
      4'd9, 4'd10:          fix = 4'sd3;
      4'd8:                 fix = 4'sd2;
      4'd2, 4'd6, 4'd7:     fix = 4'sd1;
      default:              fix = 4'sd0;
    endcase
    count_o = $signed({2'b0, y365}) + $signed({12'b0, quad}) + m_term
            + $signed({13'b0, day_i}) + $signed({17'b0, leap_inc})
            + DAYCNT_W'(fix) - 18'sd35;
  end

endmodule

`default_nettype wire

FILE: rtl/core/s2l_acc_unit.sv
`default_nettype none

// shared accumulate and compare against the target day count
module s2l_acc_unit
  import s2l_pkg::*;
(
  input  logic [ACC_W-1:0] acc_i,
  input  logic [4:0]       addend_i,
  input  logic [ACC_W-1:0] target_i,
  output s2l_step_t        step_o
);

  always_comb begin
    step_o.sum = acc_i + {{(ACC_W-5){1'b0}}, addend_i};
    step_o.hit = (step_o.sum >= target_i);
  end

endmodule

`default_nettype wire

FILE: rtl/core/solar_to_lunar_date_converter_top.sv
`default_nettype none

// gregorian to chinese lunar date converter. one transfer on the slave side
// carries a date in 2000..2099 (year offset, month, day); one transfer on the
// master side returns lunar year, month, day, the leap month flag and an
// out-of-range flag (set when the date lies before lunar new year 2000 or past
// the end of the 101-year code table, with all other fields zero). the date is
// turned into a day count combinationally as it is accepted, then a sequencer
// walks the year code table one lunar month per cycle through a single shared
// add and compare unit, with an extra leap step for each leap month passed. a
// conversion's length is set by the month-by-month walk, longest for dates at
// the end of the table or past it. the slave side is ready only in idle; a
// finished result moves into the output register as soon as that register is
// free, and then waits there while the next date is accepted. while the output
// register still holds an unaccepted result, a newly finished one keeps the
// slave side stalled
module solar_to_lunar_date_converter_top
  import s2l_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // year_in[6:0], month_in[10:7], day_in[15:11]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // lunar_year[11:0], lunar_month[15:12],
                                       // lunar_day[20:16], zero pad[23:21]
  output logic [1:0]  m_axis_tuser_o   // leap_month[0], out_of_range[1]
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MONTH,
    ST_LEAP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic        leap;
    logic [4:0]  day;
    logic        oor;
  } result_t;

  localparam logic [YIDX_W-1:0] LAST_YEAR  = YIDX_W'(TABLE_YEARS - 1);
  localparam logic [3:0]        LAST_MONTH = 4'(MONTHS - 1);

  state_e               state_q, state_d;
  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [ACC_W-1:0]     target_q, target_d;
  logic [YIDX_W-1:0]    yi_q, yi_d;
  logic [3:0]           mi_q, mi_d;
  logic                 leap_vld_q, leap_vld_d;   // a leap month sits in this year
  logic [3:0]           leap_idx_q, leap_idx_d;   // regular month it follows
  result_t              res_q, res_d;
  logic                 out_vld_q, out_vld_d;
  result_t              out_q, out_d;

  logic signed [DAYCNT_W-1:0] day_count;
  logic [15:0]          code;
  logic                 len_bit;
  logic [4:0]           addend;
  s2l_step_t            step;
  logic [4:0]           over;
  logic [4:0]           lunar_day;
  logic                 in_xfer;

  s2l_day_count u_day_count (
    .year_i  (s_axis_tdata_i[6:0]),
    .month_i (s_axis_tdata_i[10:7]),
    .day_i   (s_axis_tdata_i[15:11]),
    .count_o (day_count)
  );

  assign code    = year_code(yi_q);
  assign len_bit = code[mi_q];
  // month step adds 29 or 30, leap step adds 16 plus the year's top nibble
  assign addend  = (state_q == ST_LEAP) ? (LEAP_BASE + {1'b0, code[15:12]})
                                        : (SHORT_MONTH + {4'b0, len_bit});

  s2l_acc_unit u_acc_unit (
    .acc_i    (acc_q),
    .addend_i (addend),
    .target_i (target_q),
    .step_o   (step)
  );

  // days left over past the target, folded into the day-of-month formula (mod 32)
  assign over      = step.sum[4:0] - target_q[4:0];
  assign lunar_day = SHORT_MONTH + {4'b0, len_bit} - over;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d    = state_q;
    acc_d      = acc_q;
    target_d   = target_q;
    yi_d       = yi_q;
    mi_d       = mi_q;
    leap_vld_d = leap_vld_q;
    leap_idx_d = leap_idx_q;
    res_d      = res_q;
    out_vld_d  = out_vld_q;
    out_d      = out_q;

    if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          acc_d      = '0;
          yi_d       = '0;
          mi_d       = '0;
          leap_vld_d = 1'b0;
          leap_idx_d = '0;
          target_d   = day_count[ACC_W-1:0];
          res_d      = '0;
          if (day_count <= 0) begin
            // before lunar new year 2000
            res_d.oor = 1'b1;
            state_d   = ST_DONE;
          end else begin
            state_d = ST_MONTH;
          end
        end
      end

      ST_MONTH, ST_LEAP: begin
        acc_d = step.sum;
        if (step.hit) begin
          res_d.year  = BASE_YEAR + {{(12-YIDX_W){1'b0}}, yi_q};
          res_d.month = mi_q + 4'd1;
          res_d.leap  = (state_q == ST_LEAP);
          res_d.day   = lunar_day;
          res_d.oor   = 1'b0;
          state_d     = ST_DONE;
        end else if ((state_q == ST_MONTH) && leap_vld_q && (mi_q == leap_idx_q)) begin
          state_d = ST_LEAP;
        end else if (mi_q == LAST_MONTH) begin
          // end of the lunar year
          if (yi_q == LAST_YEAR) begin
            res_d   = '0;
            res_d.oor = 1'b1;
            state_d = ST_DONE;
          end else begin
            yi_d       = yi_q + 1'b1;
            mi_d       = '0;
            leap_vld_d = (code[15:12] != 4'd0);
            leap_idx_d = code[15:12] - 4'd1;
            state_d    = ST_MONTH;
          end
        end else begin
          mi_d    = mi_q + 4'd1;
          state_d = ST_MONTH;
        end
      end

      ST_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d = 1'b1;
          out_d     = res_q;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      acc_q      <= '0;
      target_q   <= '0;
      yi_q       <= '0;
      mi_q       <= '0;
      leap_vld_q <= 1'b0;
      leap_idx_q <= '0;
      res_q      <= '0;
      out_vld_q  <= 1'b0;
      out_q      <= '0;
    end else begin
      state_q    <= state_d;
      acc_q      <= acc_d;
      target_q   <= target_d;
      yi_q       <= yi_d;
      mi_q       <= mi_d;
      leap_vld_q <= leap_vld_d;
      leap_idx_q <= leap_idx_d;
      res_q      <= res_d;
      out_vld_q  <= out_vld_d;
      out_q      <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, out_q.day, out_q.month, out_q.year};
  assign m_axis_tuser_o  = {out_q.oor, out_q.leap};

  // the walk never runs past the last table year or the last month
  a_walk_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_MONTH) || (state_q == ST_LEAP)) |->
      ((yi_q <= LAST_YEAR) && (mi_q <= LAST_MONTH)))
    else $error("walk index out of bounds");

  // a leap step only follows the month that carries the leap
  a_leap_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LEAP) |-> ($past(state_q) == ST_MONTH) && leap_vld_q
      && (mi_q == leap_idx_q))
    else $error("leap step entered from wrong place");

  // out-of-range results carry zeros everywhere else
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |->
      ((m_axis_tdata_o == 24'd0) && !m_axis_tuser_o[0]))
    else $error("out-of-range result with nonzero fields");

  // valid results name a real lunar month and a covered year
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[1]) |->
      ((out_q.month >= 4'd1) && (out_q.month <= 4'(MONTHS))
       && (out_q.year >= BASE_YEAR)
       && (out_q.year <= BASE_YEAR + 12'(TABLE_YEARS - 1))))
    else $error("lunar result out of range");

  // an accepted date leaves the idle state in the next cycle
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q != ST_IDLE))
    else $error("accepted date did not start a conversion");

endmodule

`default_nettype wire

FILE: tb/lunar_date_checker.sv
module lunar_date_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        date_tvalid_i,
  input  logic        date_tready_i,
  input  logic [15:0] date_tdata_i,    // year_in[6:0], month_in[10:7], day_in[15:11]
  input  logic        lunar_tvalid_i,
  input  logic        lunar_tready_i,
  input  logic [23:0] lunar_tdata_i,   // lunar_year[11:0], lunar_month[15:12], lunar_day[20:16]
  input  logic [1:0]  lunar_tuser_i,   // leap_month[0], out_of_range[1]
  output int unsigned mismatches_o,
  output int unsigned pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CODE_YEARS = 101;

  // month lengths in bits 11..0, next year's leap position in bits 15..12
  localparam logic [0:CODE_YEARS-1][15:0] YEAR_CODES = {
    16'h4693, 16'hDA9B, 16'h052B, 16'h2A5B, 16'hDAAE, 16'h756A, 16'hDDD5, 16'h0BA4,
    16'h5B49, 16'hDD53, 16'h0A95, 16'h452D, 16'hD55D, 16'h9AB5, 16'hDBAA, 16'h05D2,
    16'h6DA5, 16'hEE8A, 16'h0D4A, 16'h4C95, 16'hDA9E, 16'h0556, 16'h2AB5, 16'hDADA,
    16'h66D2, 16'hD765, 16'h0725, 16'h564B, 16'hD657, 16'h0CAB, 16'h355A, 16'hD56E,
    16'hBB69, 16'hDF52, 16'h0B52, 16'h5B25, 16'hDD2B, 16'h0A4B, 16'h54AB, 16'hD2BB,
    16'h05AD, 16'h2B6A, 16'hDDAA, 16'h7D92, 16'hDEA5, 16'h0D25, 16'h5A55, 16'hEA4D,
    16'h04B6, 16'h35B5, 16'hE6D2, 16'h8EC9, 16'hDF92, 16'h0E92, 16'h6D26, 16'hE516,
    16'h0A57, 16'h44D6, 16'hE365, 16'h0755, 16'h3749, 16'hD74B, 16'h7693, 16'hDAAB,
    16'h052B, 16'h5A5B, 16'hDABA, 16'h056A, 16'h4B65, 16'hDBAA, 16'h8B4A, 16'hDD95,
    16'h0A95, 16'h652D, 16'hD56D, 16'h0AB5, 16'h55AA, 16'hE5C5, 16'h0DA5, 16'h3D4A,
    16'hDE4D, 16'h7C96, 16'hDCCE, 16'h0556, 16'h5AB5, 16'hEAD2, 16'h06D2, 16'h5EA5,
    16'hD72A, 16'h868B, 16'hD697, 16'h04AB, 16'h655B, 16'hE556, 16'h0B6A, 16'h4752,
    16'hDB95, 16'h0B25, 16'h2A8B, 16'hDA4F, 16'h04AB
  };

  typedef struct packed {
    logic [11:0] lunar_year;
    logic [3:0]  lunar_month;
    logic [4:0]  lunar_day;
    logic        leap_month;
    logic        out_of_range;
  } lunar_date_t;

  lunar_date_t lunar_dates_due[$];
  lunar_date_t got;
  lunar_date_t want;
  int unsigned mismatch_count = 0;
  int unsigned due_count      = 0;

  assign mismatches_o = mismatch_count;
  assign pending_o    = due_count;

  function automatic lunar_date_t predict_lunar_date(input logic [6:0] yy,
                                                     input logic [3:0] mm,
                                                     input logic [4:0] dd);
    lunar_date_t res;
    int          day_num;
    int unsigned goal;
    int unsigned acc;
    int unsigned leap_pos;
    int unsigned code;
    int unsigned bits;
    int unsigned yi;
    int unsigned mi;
    bit          found;
    bit          in_leap;
    res = '0;
    res.out_of_range = 1'b1;
    day_num = int'(yy) * 365 + ((int'(yy) + 3) >>> 2) + (int'(mm) - 1) * 30 + int'(dd);
    // gregorian leap day already passed, 2100 excluded
    if (mm > 4'd2 && yy[1:0] == 2'd0 && yy != 7'd100) day_num++;
    case (mm)
      4'd3:                 day_num -= 1;
      4'd11, 4'd12:         day_num += 4;
      4'd9, 4'd10:          day_num += 3;
      4'd8:                 day_num += 2;
      4'd2, 4'd6, 4'd7:     day_num += 1;
      default:              day_num += 0;
    endcase
    // day 1 is lunar new year 2000
    day_num -= 35;
    if (day_num <= 0) return res;
    goal     = day_num;
    acc      = 0;
    leap_pos = 8'hFF;
    bits     = 0;
    mi       = 0;
    yi       = 0;
    found    = 1'b0;
    in_leap  = 1'b0;
    while (!found && yi < CODE_YEARS) begin
      code = YEAR_CODES[yi];
      bits = code;
      mi   = 0;
      while (!found && mi < 12) begin
        acc += 29 + (bits & 1);
        if (acc >= goal) begin
          found = 1'b1;
        end else if (mi == leap_pos) begin
          // inserted month after this one, length from the top nibble
          acc += 16 + (code >> 12);
          if (acc >= goal) begin
            found   = 1'b1;
            in_leap = 1'b1;
          end
        end
        if (!found) begin
          bits >>= 1;
          mi++;
        end
      end
      if (!found) begin
        leap_pos = (bits - 1) & 8'hFF;
        yi++;
      end
    end
    if (!found) return res;
    res.lunar_year   = 12'(yi + 2000);
    res.lunar_month  = 4'(mi + 1);
    res.leap_month   = in_leap;
    res.lunar_day    = 5'(29 + (bits & 1) - (acc - goal));
    res.out_of_range = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned want_v);
    if (mismatch_count < 30)
      $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got_v, want_v);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (lunar_tvalid_i && lunar_tready_i) begin
        got.lunar_year   = lunar_tdata_i[11:0];
        got.lunar_month  = lunar_tdata_i[15:12];
        got.lunar_day    = lunar_tdata_i[20:16];
        got.leap_month   = lunar_tuser_i[0];
        got.out_of_range = lunar_tuser_i[1];
        if (lunar_dates_due.size() == 0) begin
          report_mismatch("unexpected result", lunar_tdata_i, 0);
        end else begin
          want = lunar_dates_due.pop_front();
          if (got.lunar_year != want.lunar_year)
            report_mismatch("lunar_year", got.lunar_year, want.lunar_year);
          if (got.lunar_month != want.lunar_month)
            report_mismatch("lunar_month", got.lunar_month, want.lunar_month);
          if (got.lunar_day != want.lunar_day)
            report_mismatch("lunar_day", got.lunar_day, want.lunar_day);
          if (got.leap_month != want.leap_month)
            report_mismatch("leap_month", got.leap_month, want.leap_month);
          if (got.out_of_range != want.out_of_range)
            report_mismatch("out_of_range", got.out_of_range, want.out_of_range);
        end
      end
      if (date_tvalid_i && date_tready_i)
        lunar_dates_due.push_back(predict_lunar_date(date_tdata_i[6:0], date_tdata_i[10:7],
                                                     date_tdata_i[15:11]));
      due_count = lunar_dates_due.size();
    end
  end

endmodule

FILE: tb/tb.sv
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  // a conversion walks the table month by month and the receiver holds off once
  // for LONG_HOLD, so this limit leaves a wide margin
  localparam int unsigned IDLE_LIMIT   = 20000;
  localparam int unsigned LONG_HOLD    = 4000;
  localparam int unsigned HOLD_AT      = 40;    // result count that starts the long hold
  localparam int unsigned RANDOM_DATES = 400;
  localparam int unsigned DRAIN_AT     = 200;   // random date before which the sender drains
  localparam int unsigned TAIL_CYCLES  = 1300;  // one full walk after the last result

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        date_tvalid  = 1'b0;
  logic        date_tready;
  logic [15:0] date_tdata   = '0;   // year_in[6:0], month_in[10:7], day_in[15:11]
  logic        lunar_tvalid;
  logic        lunar_tready = 1'b0;
  logic [23:0] lunar_tdata;         // lunar_year[11:0], lunar_month[15:12], lunar_day[20:16]
  logic [1:0]  lunar_tuser;         // leap_month[0], out_of_range[1]

  int unsigned mismatches;
  int unsigned pending_dates;
  int unsigned idle_cycles = 0;
  int unsigned results_seen = 0;
  bit          tx_no_gaps = 1'b0;
  bit          rx_no_gaps = 1'b0;

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  solar_to_lunar_date_converter_top i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (date_tvalid),
    .s_axis_tready_o (date_tready),
    .s_axis_tdata_i  (date_tdata),
    .m_axis_tvalid_o (lunar_tvalid),
    .m_axis_tready_i (lunar_tready),
    .m_axis_tdata_o  (lunar_tdata),
    .m_axis_tuser_o  (lunar_tuser)
  );

  lunar_date_checker i_lunar_date_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .date_tvalid_i  (date_tvalid),
    .date_tready_i  (date_tready),
    .date_tdata_i   (date_tdata),
    .lunar_tvalid_i (lunar_tvalid),
    .lunar_tready_i (lunar_tready),
    .lunar_tdata_i  (lunar_tdata),
    .lunar_tuser_i  (lunar_tuser),
    .mismatches_o   (mismatches),
    .pending_o      (pending_dates)
  );

  // gap length: mostly none or short, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 200);
  endfunction

  // offer one date and return at the falling edge after its transfer,
  // tvalid left high so back-to-back dates need no second assignment
  task automatic send_date(input logic [6:0] yy, input logic [3:0] mm, input logic [4:0] dd);
    int unsigned gap;
    gap = tx_no_gaps ? 0 : idle_len();
    if (gap != 0) begin
      date_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    date_tvalid <= 1'b1;
    date_tdata  <= {dd, mm, yy};
    do @(posedge clk); while (!date_tready);
    @(negedge clk);
  endtask

  // watchdog: ends the run when no transfer happens on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (date_tvalid && date_tready) || (lunar_tvalid && lunar_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // result side: random stalls, stretches with none, and one long hold-off
  // that lets the block fill up and stall its date input
  initial begin
    int unsigned hold;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (results_seen % 16 == 0) rx_no_gaps = ($urandom_range(0, 3) == 0);
      if (results_seen == HOLD_AT) hold = LONG_HOLD;
      else hold = rx_no_gaps ? 0 : idle_len();
      if (hold != 0) begin
        lunar_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      lunar_tready <= 1'b1;
      do @(posedge clk); while (!lunar_tvalid);
      results_seen++;
      @(negedge clk);
    end
  end

  // date side: directed dates, then random ones, then the verdict
  initial begin
    int unsigned pick;
    logic [6:0]  yy;
    logic [3:0]  mm;
    logic [4:0]  dd;
    logic [4:0]  month_len;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // before the table, the last day before lunar new year 2000, and the first day
    send_date(7'd0, 4'd1, 5'd1);
    send_date(7'd0, 4'd2, 5'd4);
    send_date(7'd0, 4'd2, 5'd5);
    // month and day out of the calendar range
    send_date(7'd0, 4'd0, 5'd0);
    send_date(7'd0, 4'd13, 5'd15);
    send_date(7'd5, 4'd14, 5'd31);
    send_date(7'd50, 4'd15, 5'd0);
    // inside inserted leap months (2001, 2020, 2023) and near their ends
    send_date(7'd1, 4'd6, 5'd1);
    send_date(7'd1, 4'd6, 5'd20);
    send_date(7'd20, 4'd6, 5'd1);
    send_date(7'd23, 4'd4, 5'd1);
    send_date(7'd23, 4'd4, 5'd19);
    // gregorian leap day handling, 2100 not a leap year
    send_date(7'd12, 4'd2, 5'd29);
    send_date(7'd12, 4'd3, 5'd1);
    send_date(7'd100, 4'd1, 5'd1);
    send_date(7'd100, 4'd3, 5'd1);
    // end of the covered range and past it with every bit set
    send_date(7'd99, 4'd12, 5'd31);
    send_date(7'd127, 4'd15, 5'd31);
    // assorted month corrections
    send_date(7'd64, 4'd8, 5'd16);
    send_date(7'd4, 4'd12, 5'd31);
    send_date(7'd33, 4'd9, 5'd30);
    send_date(7'd57, 4'd11, 5'd30);
    send_date(7'd16, 4'd10, 5'd31);
    send_date(7'd87, 4'd7, 5'd31);

    for (int unsigned n = 0; n < RANDOM_DATES; n++) begin
      if (n % 16 == 0) tx_no_gaps = ($urandom_range(0, 3) == 0);
      // pause once until every pending conversion has come back
      if (n == DRAIN_AT) begin
        date_tvalid <= 1'b0;
        do @(negedge clk); while (pending_dates != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // well-formed calendar date
        yy = $urandom_range(0, 99);
        mm = $urandom_range(1, 12);
        case (mm)
          4'd2:                      month_len = (yy[1:0] == 2'd0) ? 5'd29 : 5'd28;
          4'd4, 4'd6, 4'd9, 4'd11:   month_len = 5'd30;
          default:                   month_len = 5'd31;
        endcase
        dd = $urandom_range(1, month_len);
      end else if (pick < 85) begin
        // near the two ends of the table
        case ($urandom_range(0, 3))
          0:       yy = 7'd0;
          1:       yy = 7'd1;
          2:       yy = 7'd98;
          default: yy = 7'd99;
        endcase
        mm = $urandom_range(1, 12);
        dd = $urandom_range(1, 31);
      end else begin
        // any bit pattern the fields allow
        yy = $urandom_range(0, 127);
        mm = $urandom_range(0, 15);
        dd = $urandom_range(0, 31);
      end
      send_date(yy, mm, dd);
    end
    date_tvalid <= 1'b0;

    // drain, then leave room for a stray late result
    do @(negedge clk); while (pending_dates != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
